// ----- rtl/olpar_pkg.sv -----
// ----------------------------------------------------------------------------
// olpar_pkg: shared types and constants for the ordered key list
// Operation and status codes, request and result word layouts, defaults.
// ----------------------------------------------------------------------------
package olpar_pkg;

   // field widths
   localparam int KeyW    = 10;
   localparam int OpW     = 2;
   localparam int StatusW = 3;
   localparam int PosW    = 4;
   localparam int CountW  = 5;

   // defaults
   localparam int          DefDepth  = 16;
   localparam logic [KeyW-1:0] MaxKeyReset = KeyW'(999);

   typedef enum logic [OpW-1:0] {
      OpAppend = 2'd0,
      OpUrgent = 2'd1,
      OpRemove = 2'd2,
      OpUnused = 2'd3
   } op_type;

   typedef enum logic [StatusW-1:0] {
      StDone    = 3'd0,
      StFull    = 3'd1,
      StDup     = 3'd2,
      StMissing = 3'd3,
      StInvalid = 3'd4
   } status_type;

   typedef struct packed {
      op_type          op;
      logic [KeyW-1:0] key;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [PosW-1:0]   position;
      logic [CountW-1:0] count;
   } rsp_type;

   typedef enum logic [1:0] {
      StateIdle,
      StateScan,
      StateIns,
      StateRm
   } state_type;

endpackage

// ----- rtl/olpar_store.sv -----
// ----------------------------------------------------------------------------
// olpar_store: key storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module olpar_store #(
   parameter int DEPTH = olpar_pkg::DefDepth,
   localparam int IdxW = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        we,
   input  logic [IdxW-1:0]             waddr,
   input  logic [olpar_pkg::KeyW-1:0]  wdata,
   input  logic [IdxW-1:0]             raddr,
   output logic [olpar_pkg::KeyW-1:0]  rdata
);

   logic [olpar_pkg::KeyW-1:0] mem [DEPTH];
   logic [olpar_pkg::KeyW-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/olpar_ctrl.sv -----
// ----------------------------------------------------------------------------
// olpar_ctrl: list sequencer
// Scans the stored keys one word a cycle through a single comparator, then
// moves entries one slot a cycle for head insert or removal.
// ----------------------------------------------------------------------------
module olpar_ctrl #(
   parameter int DEPTH = olpar_pkg::DefDepth,
   localparam int IdxW = $clog2(DEPTH),
   localparam int CntW = $clog2(DEPTH + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  olpar_pkg::req_type          req,
   input  logic [olpar_pkg::KeyW-1:0]  max_key,
   output logic                        mem_we,
   output logic [IdxW-1:0]             mem_waddr,
   output logic [olpar_pkg::KeyW-1:0]  mem_wdata,
   output logic [IdxW-1:0]             mem_raddr,
   input  logic [olpar_pkg::KeyW-1:0]  mem_rdata,
   output logic                        rsp_valid,
   output olpar_pkg::rsp_type          rsp
);

   localparam int PosW   = olpar_pkg::PosW;
   localparam int CountW = olpar_pkg::CountW;

   olpar_pkg::state_type         state_ff, state_in;
   olpar_pkg::op_type            op_ff, op_in;
   logic [olpar_pkg::KeyW-1:0]   key_ff, key_in;
   logic [CntW-1:0]              occ_ff, occ_in;
   logic [CntW-1:0]              idx_ff, idx_in;
   logic                         pend_ff, pend_in;
   logic [IdxW-1:0]              wa_ff, wa_in;
   logic [IdxW-1:0]              pos_ff, pos_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   olpar_pkg::rsp_type           rsp_ff, rsp_in;

   logic [CntW-1:0] idx_inc, idx_dec;
   logic            key_ok;
   logic            match;

   assign idx_inc = idx_ff + CntW'(1);
   assign idx_dec = idx_ff - CntW'(1);
   assign key_ok  = (req.key != '0) && (req.key <= max_key);
   // the shared comparator: last read word against the request key
   assign match   = pend_ff && (mem_rdata == key_ff);

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= olpar_pkg::StateIdle;
         occ_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      key_ff <= key_in;
      idx_ff <= idx_in;
      wa_ff  <= wa_in;
      pos_ff <= pos_in;
      rsp_ff <= rsp_in;
   end

   // next state and datapath control
   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      key_in          = key_ff;
      occ_in          = occ_ff;
      idx_in          = idx_ff;
      pend_in         = pend_ff;
      wa_in           = wa_ff;
      pos_in          = pos_ff;
      rsp_valid_in    = 1'b0;
      rsp_in          = rsp_ff;
      mem_we          = 1'b0;
      mem_waddr       = wa_ff;
      mem_wdata       = mem_rdata;
      mem_raddr       = idx_ff[IdxW-1:0];

      unique case (state_ff)
         olpar_pkg::StateIdle: begin
            if (start) begin
               op_in           = req.op;
               key_in          = req.key;
               idx_in          = '0;
               pend_in         = 1'b0;
               rsp_in.position = '0;
               unique case (req.op) inside
                  olpar_pkg::OpAppend, olpar_pkg::OpUrgent: begin
                     if (occ_ff == CntW'(DEPTH)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = olpar_pkg::StFull;
                     end else if (!key_ok) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = olpar_pkg::StInvalid;
                     end else begin
                        state_in = olpar_pkg::StateScan;
                     end
                  end
                  olpar_pkg::OpRemove: begin
                     if (!key_ok) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = olpar_pkg::StInvalid;
                     end else begin
                        state_in = olpar_pkg::StateScan;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = olpar_pkg::StInvalid;
                  end
               endcase
            end
         end

         // read one word a cycle, compare the word read the cycle before
         olpar_pkg::StateScan: begin
            if (match) begin
               pend_in = 1'b0;
               if (op_ff == olpar_pkg::OpRemove) begin
                  // found at idx-1; the move starts by reading idx
                  pos_in   = idx_dec[IdxW-1:0];
                  state_in = olpar_pkg::StateRm;
               end else begin
                  rsp_valid_in    = 1'b1;
                  rsp_in.status   = olpar_pkg::StDup;
                  rsp_in.position = '0;
                  state_in        = olpar_pkg::StateIdle;
               end
            end else if (idx_ff == occ_ff) begin
               pend_in = 1'b0;
               unique case (op_ff)
                  olpar_pkg::OpAppend: begin
                     mem_we          = 1'b1;
                     mem_waddr       = occ_ff[IdxW-1:0];
                     mem_wdata       = key_ff;
                     occ_in          = occ_ff + CntW'(1);
                     rsp_valid_in    = 1'b1;
                     rsp_in.status   = olpar_pkg::StDone;
                     rsp_in.position = PosW'(occ_ff);
                     state_in        = olpar_pkg::StateIdle;
                  end
                  olpar_pkg::OpUrgent: begin
                     idx_in   = occ_ff;
                     state_in = olpar_pkg::StateIns;
                  end
                  default: begin
                     rsp_valid_in    = 1'b1;
                     rsp_in.status   = olpar_pkg::StMissing;
                     rsp_in.position = '0;
                     state_in        = olpar_pkg::StateIdle;
                  end
               endcase
            end else begin
               idx_in  = idx_inc;
               pend_in = 1'b1;
            end
         end

         // move entries back one slot, last to first, then put key at head
         olpar_pkg::StateIns: begin
            if (pend_ff) begin
               mem_we = 1'b1;
            end
            if (idx_ff != '0) begin
               mem_raddr = idx_dec[IdxW-1:0];
               wa_in     = idx_ff[IdxW-1:0];
               idx_in    = idx_dec;
               pend_in   = 1'b1;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               mem_we          = 1'b1;
               mem_waddr       = '0;
               mem_wdata       = key_ff;
               occ_in          = occ_ff + CntW'(1);
               rsp_valid_in    = 1'b1;
               rsp_in.status   = olpar_pkg::StDone;
               rsp_in.position = '0;
               state_in        = olpar_pkg::StateIdle;
            end
         end

         // move later entries forward one slot
         olpar_pkg::StateRm: begin
            if (pend_ff) begin
               mem_we = 1'b1;
            end
            if (idx_ff != occ_ff) begin
               mem_raddr = idx_ff[IdxW-1:0];
               wa_in     = idx_dec[IdxW-1:0];
               idx_in    = idx_inc;
               pend_in   = 1'b1;
            end else begin
               pend_in         = 1'b0;
               occ_in          = occ_ff - CntW'(1);
               rsp_valid_in    = 1'b1;
               rsp_in.status   = olpar_pkg::StDone;
               rsp_in.position = PosW'(pos_ff);
               state_in        = olpar_pkg::StateIdle;
            end
         end

         default: begin
            state_in = olpar_pkg::StateIdle;
         end
      endcase

      if (rsp_valid_in) begin
         rsp_in.count = CountW'(occ_in);
      end
   end

   assign busy      = (state_ff != olpar_pkg::StateIdle);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ----- rtl/ordered_list_push_append_remove.sv -----
// ----------------------------------------------------------------------------
// ordered_list_push_append_remove: ordered key list with delete by key
// Keeps up to DEPTH nonzero keys in order; append, head insert, remove.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive req_data (op, key) and raise start; the word is taken at
//   the clock edge where start is high and busy is low. busy stays high
//   while the list works on it.
//   Result: rsp_data (status, position, count) is shown for one cycle with
//   rsp_valid high. There is no back-pressure; the receiver must take it.
//   Config: csr_data holds max_key, written when csr_valid and csr_ready.
// Flow, from acceptance to rsp_valid:
//   rejected at once (full, bad key, unused op): no scan
//   append or duplicate: scan the list (one comparator, one word a cycle)
//   head insert: scan the whole list, then one move a cycle
//   remove: scan to the key, then move the tail forward
//   The worst case is a head insert with DEPTH-1 keys listed, set by the
//   single read port of the key store. A new request may be given in
//   the cycle the result shows.
// Reset empties the list (count to zero) and sets max_key to 999; the key
// store itself is not swept, what slots at or past the count hold is never used.
// ----------------------------------------------------------------------------
module ordered_list_push_append_remove #(
   parameter int DEPTH = olpar_pkg::DefDepth
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  olpar_pkg::req_type          req_data,
   output logic                        rsp_valid,
   output olpar_pkg::rsp_type          rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [olpar_pkg::KeyW-1:0]  csr_data
);

   localparam int IdxW = $clog2(DEPTH);

   logic [olpar_pkg::KeyW-1:0] max_key_ff;
   logic                       mem_we;
   logic [IdxW-1:0]            mem_waddr;
   logic [IdxW-1:0]            mem_raddr;
   logic [olpar_pkg::KeyW-1:0] mem_wdata;
   logic [olpar_pkg::KeyW-1:0] mem_rdata;

   // max_key register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_key_ff <= olpar_pkg::MaxKeyReset;
      end else if (csr_valid && csr_ready) begin
         max_key_ff <= csr_data;
      end
   end

   olpar_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req_data),
      .max_key   (max_key_ff),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

   olpar_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // an accepted word either starts work or answers at once
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted request neither busy nor answered");

   // position is zero unless the request was done
   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != olpar_pkg::StDone) |-> (rsp_data.position == '0))
      else $error("nonzero position on a refused request");

   // a full answer reports a full list
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == olpar_pkg::StFull)
         |-> (rsp_data.count == olpar_pkg::CountW'(DEPTH)))
      else $error("full status with list not full");

   // no result while the sequencer is still busy
   a_no_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

endmodule

// ----- bench/olpar_list_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olpar_list_checker: scoreboard for the ordered key list
// Watches the request, result and max_key channels. It keeps its own copy of
// the list and limit, works out the result word for each accepted request,
// and compares each result word, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module olpar_list_checker #(
   parameter int DEPTH = olpar_pkg::DefDepth
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  olpar_pkg::req_type         req_data,
   input  logic                       rsp_valid,
   input  olpar_pkg::rsp_type         rsp_data,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [olpar_pkg::KeyW-1:0] csr_data,
   output int                         fail_count,
   output int                         outcomes_due
);
   import olpar_pkg::*;

   // shadow list and limit
   logic [KeyW-1:0] shadow_keys [DEPTH];
   int              shadow_len;
   logic [KeyW-1:0] shadow_max_key;

   rsp_type queued_outcomes [$];

   initial begin
      fail_count   = 0;
      outcomes_due = 0;
   end

   function automatic int locate_key(logic [KeyW-1:0] key);
      for (int idx = 0; idx < shadow_len; idx++) begin
         if (shadow_keys[idx] == key) return idx;
      end
      return -1;
   endfunction

   // apply one request to the shadow list and return the word it should give
   function automatic rsp_type apply_list_request(req_type word);
      rsp_type    outcome;
      status_type st;
      int         slot;
      int         hit;
      logic       key_ok;
      st     = StDone;
      slot   = 0;
      key_ok = (word.key != '0) && (word.key <= shadow_max_key);
      case (word.op)
         OpAppend, OpUrgent: begin
            // full wins over a bad key, a bad key over a duplicate
            if (shadow_len >= DEPTH) st = StFull;
            else if (!key_ok) st = StInvalid;
            else if (locate_key(word.key) >= 0) st = StDup;
            else if (word.op == OpAppend) begin
               slot = shadow_len;
               shadow_keys[shadow_len] = word.key;
               shadow_len++;
            end else begin
               for (int idx = shadow_len; idx > 0; idx--)
                  shadow_keys[idx] = shadow_keys[idx-1];
               shadow_keys[0] = word.key;
               shadow_len++;
            end
         end
         OpRemove: begin
            hit = key_ok ? locate_key(word.key) : -1;
            if (!key_ok) st = StInvalid;
            else if (hit < 0) st = StMissing;
            else begin
               slot = hit;
               for (int idx = hit; idx < DEPTH - 1; idx++)
                  shadow_keys[idx] = shadow_keys[idx+1];
               shadow_keys[DEPTH-1] = '0;
               shadow_len--;
            end
         end
         default: st = StInvalid;
      endcase
      outcome.status   = st;
      outcome.position = (st == StDone) ? PosW'(slot) : '0;
      outcome.count    = CountW'(shadow_len);
      return outcome;
   endfunction

   // sample all channels at the rising edge
   always @(posedge clock) begin
      rsp_type due;
      if (reset) begin
         queued_outcomes.delete();
         for (int idx = 0; idx < DEPTH; idx++) shadow_keys[idx] = '0;
         shadow_len     = 0;
         shadow_max_key = MaxKeyReset;
      end else begin
         // result word first: a new request may be taken in the same cycle
         if (rsp_valid) begin
            if (queued_outcomes.size() == 0) begin
               $error("result word with nothing due: status %0d position %0d count %0d",
                      rsp_data.status, rsp_data.position, rsp_data.count);
               fail_count++;
            end else begin
               due = queued_outcomes.pop_front();
               if (rsp_data.status !== due.status) begin
                  $error("status: expected %0d, got %0d", due.status, rsp_data.status);
                  fail_count++;
               end
               if (rsp_data.position !== due.position) begin
                  $error("position: expected %0d, got %0d", due.position, rsp_data.position);
                  fail_count++;
               end
               if (rsp_data.count !== due.count) begin
                  $error("count: expected %0d, got %0d", due.count, rsp_data.count);
                  fail_count++;
               end
            end
         end
         if (start && !busy) queued_outcomes.push_back(apply_list_request(req_data));
         if (csr_valid && csr_ready) shadow_max_key = csr_data;
      end
      outcomes_due <= queued_outcomes.size();
   end

endmodule

// ----- bench/tb_ordered_list_push_append_remove.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_list_push_append_remove: testbench for the ordered key list
// Directed words for the edge cases, then random append, head insert and
// remove traffic over several max_key settings, with random sender gaps.
// The checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_ordered_list_push_append_remove;
   import olpar_pkg::*;

   localparam int Depth      = DefDepth;
   localparam int CycleLimit = 400000;
   localparam int NumPhases  = 6;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   req_type           req_data;
   logic              rsp_valid;
   rsp_type           rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [KeyW-1:0]   csr_data;
   int                fail_count;
   int                outcomes_due;
   int                cycle_count;

   // stimulus view of the limit and the current key pool
   int                limit_now;
   int                pool_base;

   // max_key per phase (-1: random) and random words per phase
   int phase_limit [NumPhases] = '{1023, 1, 0, -1, 16, 999};
   int phase_words [NumPhases] = '{90, 25, 10, 110, 60, 100};

   ordered_list_push_append_remove #(.DEPTH(Depth)) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   olpar_list_checker #(.DEPTH(Depth)) u_checker (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .fail_count   (fail_count),
      .outcomes_due (outcomes_due)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("FAIL ordered_list_push_append_remove");
         $finish;
      end
   end

   // present one request word and hold it until taken
   task automatic send_word(op_type op, logic [KeyW-1:0] key);
      req_type word;
      word.op  = op;
      word.key = key;
      @(negedge clock);
      start    <= 1'b1;
      req_data <= word;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // sender gap, with junk on the data lines
   task automatic rest(int cycles);
      @(negedge clock);
      start    <= 1'b0;
      req_data <= req_type'($urandom_range(0, 4095));
      repeat (cycles - 1) @(negedge clock);
   endtask

   // drain everything, then write max_key
   task automatic set_max_key(int value);
      rest(1);
      wait (outcomes_due == 0);
      repeat (8) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= KeyW'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      limit_now  = value;
   endtask

   // mostly a small pool so duplicates, hits and a full list are common
   function automatic logic [KeyW-1:0] pick_key();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) return KeyW'(pool_base + $urandom_range(0, 23));
      if (roll < 88) return KeyW'($urandom_range(0, 1023));
      if (roll < 94 || limit_now >= 1023) return '0;
      return KeyW'($urandom_range(limit_now + 1, 1023));
   endfunction

   function automatic op_type pick_op(bit filling);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 3) return OpUnused;
      if (filling) begin
         if (roll < 50) return OpAppend;
         if (roll < 83) return OpUrgent;
         return OpRemove;
      end
      if (roll < 18) return OpAppend;
      if (roll < 30) return OpUrgent;
      return OpRemove;
   endfunction

   initial begin
      bit filling;
      bit gappy;
      int limit_val;
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      limit_now = 999;
      pool_base = 1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: bad keys, duplicates, missing key, unused op
      send_word(OpAppend, 10'd0);
      send_word(OpAppend, 10'd1000);
      send_word(OpAppend, 10'd1);
      send_word(OpAppend, 10'd999);
      send_word(OpAppend, 10'd1);
      send_word(OpUrgent, 10'd1023);
      send_word(OpUrgent, 10'd5);
      send_word(OpRemove, 10'd7);
      send_word(OpRemove, 10'd999);
      send_word(OpUnused, 10'd1023);
      send_word(OpRemove, 10'd0);
      // fill to one short of full (key 5 is a duplicate), then bad keys
      for (int k = 2; k < 16; k++) send_word((k % 2) ? OpUrgent : OpAppend, KeyW'(k));
      send_word(OpAppend, 10'd0);
      send_word(OpUrgent, 10'd1023);

      // random phases over several limits
      for (int ph = 0; ph < NumPhases; ph++) begin
         limit_val = (phase_limit[ph] < 0) ? $urandom_range(2, 1022) : phase_limit[ph];
         set_max_key(limit_val);
         if (limit_val == 1023) pool_base = 1000;
         else if (limit_val >= 24) pool_base = $urandom_range(1, limit_val - 23);
         else pool_base = 1;
         filling = 1'b0;
         gappy   = 1'b0;
         for (int i = 0; i < phase_words[ph]; i++) begin
            if (i % 20 == 0) filling = $urandom_range(0, 1);
            if (i % 25 == 0) gappy = $urandom_range(0, 2) != 0;
            send_word(pick_op(filling), pick_key());
            // no gaps in the closing stretch
            if (gappy && !(ph == NumPhases - 1 && i >= phase_words[ph] - 60)
                && $urandom_range(0, 99) < 35)
               rest($urandom_range(1, 19));
         end
      end

      rest(1);
      wait (outcomes_due == 0);
      repeat (2 * Depth + 10) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS ordered_list_push_append_remove");
      end else begin
         $display("FAIL ordered_list_push_append_remove");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/olpar_pkg.sv
rtl/olpar_store.sv
rtl/olpar_ctrl.sv
rtl/ordered_list_push_append_remove.sv
bench/olpar_list_checker.sv
bench/tb_ordered_list_push_append_remove.sv
